// ===== rtl/bqgr_pkg.sv =====
// ----------------------------------------------------------------------------
// bqgr_pkg
// shared types, constants and helpers of the biquad filter with gain ramp
// ----------------------------------------------------------------------------
`default_nettype none

package bqgr_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 18;

    localparam int COEF_FRAC  = 14;
    localparam int GAIN_FRAC  = 16;
    localparam int GAIN_BITS  = 17;
    localparam int LOG2_BITS  = 4;
    localparam int MAX_LOG2   = 12;
    localparam int POS_BITS   = 12;
    localparam int ACC_BITS   = 64;
    localparam int CNT_BITS   = 3;

    localparam int CFG_IDX_BITS = 3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_B0    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B1    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B2    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_A1    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_A2    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK = 3'd6;

    // reset values of the registers
    localparam int B0_RESET    = 16384;
    localparam int GAIN_RESET  = 45875;
    localparam int BLOCK_RESET = 6;

    // sequencer counter values
    localparam logic [CNT_BITS-1:0] CNT_FIN   = 3'd6;
    localparam logic [CNT_BITS-1:0] CNT_SCALE = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // multiplier operand selection
    typedef enum logic [2:0] {
        OP_B0,
        OP_B1,
        OP_B2,
        OP_A1,
        OP_A2,
        OP_RAMP,
        OP_SCALE
    } t_op;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        t_op     op;
        logic    mul_en;
        t_acc_op acc_op;
        logic    fin_load;
        logic    out_load;
    } t_ctrl;

    // saturating add or subtract at 64 bits
    function automatic logic signed [ACC_BITS-1:0] f_sat_acc(
        input logic signed [ACC_BITS-1:0] acc,
        input logic signed [ACC_BITS-1:0] val,
        input logic                       sub
    );
        logic signed [ACC_BITS:0] ext;
        logic signed [ACC_BITS:0] sum;
        begin
            ext = {val[ACC_BITS-1], val};
            if (sub) begin
                sum = {acc[ACC_BITS-1], acc} - ext;
            end else begin
                sum = {acc[ACC_BITS-1], acc} + ext;
            end
            if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
                f_sat_acc = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                          : {1'b0, {(ACC_BITS-1){1'b1}}};
            end else begin
                f_sat_acc = sum[ACC_BITS-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bqgr_in_if.sv =====
// ----------------------------------------------------------------------------
// bqgr_in_if
// input sample channel: valid, ready and one sample per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface bqgr_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/bqgr_out_if.sv =====
// ----------------------------------------------------------------------------
// bqgr_out_if
// output sample channel: valid, ready and one sample per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface bqgr_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/biquad_filter_gain_ramp.sv =====
// ----------------------------------------------------------------------------
// biquad_filter_gain_ramp
// direct form I biquad section followed by a linearly ramped output gain
// ----------------------------------------------------------------------------
// usage
//   i_in carries one signed sample per beat, o_out one filtered and scaled
//   sample per beat, in the same order. both use valid/ready.
//   coefficients, target gain and block length are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// timing
//   one shared multiplier does all seven products (five taps, the ramp
//   product and the gain product) under a small sequencer, so the block
//   takes a new sample only once the result of the last one has gone to
//   the output register.
//   i_in.ready is high only while the sequencer is idle.
// stall
//   the result sits in an output register; the next sample is accepted and
//   computed while it waits, and that one holds in its last step until the
//   register frees up.
// reset
//   synchronous active low: registers go to their defaults, the delay line,
//   block position and previous gain clear, so the first block ramps from
//   zero gain.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_filter_gain_ramp #(
    parameter int SAMPLE_BITS = bqgr_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bqgr_pkg::COEF_BITS_DEF,
    parameter int CFG_BITS    = (COEF_BITS > bqgr_pkg::GAIN_BITS) ? COEF_BITS
                                                                  : bqgr_pkg::GAIN_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [bqgr_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [CFG_BITS-1:0]                   i_cfg_data,
    bqgr_in_if.sink                                    i_in,
    bqgr_out_if.source                                 o_out
);
    import bqgr_pkg::*;

    // multiplier operand widths: a side holds coefficients, ramp delta and
    // gain; b side holds samples and the block position
    localparam int MA = (COEF_BITS > GAIN_BITS + 1) ? COEF_BITS : GAIN_BITS + 1;
    localparam int MB = (SAMPLE_BITS > POS_BITS + 1) ? SAMPLE_BITS : POS_BITS + 1;
    localparam int PW = MA + MB;
    localparam int SW = PW - GAIN_FRAC;

    localparam logic signed [ACC_BITS-1:0] ROUND_Y = ACC_BITS'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [PW-1:0]       ROUND_G = PW'(1) <<< (GAIN_FRAC - 1);

    // configuration registers
    logic signed [COEF_BITS-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [GAIN_BITS-1:0]        r_target;
    logic [LOG2_BITS-1:0]        r_log2;

    // filter state
    logic signed [SAMPLE_BITS-1:0] r_x0, r_x1, r_x2, r_y1, r_y2;
    logic [POS_BITS-1:0]           r_pos;
    logic [GAIN_BITS-1:0]          r_prev_gain;

    // datapath
    logic signed [ACC_BITS-1:0]    r_acc;
    logic signed [SAMPLE_BITS-1:0] r_y0;
    logic signed [GAIN_BITS:0]     r_gain;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic                          r_out_valid;

    t_ctrl                         ctrl;
    logic                          in_ready;
    logic                          in_beat;
    logic                          out_busy;
    logic signed [MA-1:0]          mul_a;
    logic signed [MB-1:0]          mul_b;
    logic signed [PW-1:0]          prod;

    logic [LOG2_BITS-1:0]          k;
    logic [POS_BITS-1:0]           last;
    logic [POS_BITS-1:0]           pos_j;
    logic signed [GAIN_BITS:0]     gain_diff;

    logic signed [ACC_BITS-1:0]    acc_rnd;
    logic signed [ACC_BITS-1:0]    y_sh;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic signed [PW-1:0]          ramp_sh;
    logic signed [GAIN_BITS:0]     n_gain;
    logic signed [PW-1:0]          scl_rnd;
    logic signed [SW-1:0]          scl_sh;
    logic signed [SAMPLE_BITS-1:0] scl_sat;

    assign in_beat     = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign out_busy    = r_out_valid && !o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.sample_out = r_out;

    bqgr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_busy (out_busy),
        .o_in_ready (in_ready),
        .o_ctrl     (ctrl)
    );

    // block length and position within the block
    assign k         = (r_log2 > LOG2_BITS'(MAX_LOG2)) ? LOG2_BITS'(MAX_LOG2) : r_log2;
    assign last      = POS_BITS'(((POS_BITS + 1)'(1) << k) - 1'b1);
    assign pos_j     = r_pos & last;
    assign gain_diff = $signed({1'b0, r_target}) - $signed({1'b0, r_prev_gain});

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = MA'(r_b0);
        mul_b = MB'(r_x0);
        case (ctrl.op)
            OP_B0: begin
                mul_a = MA'(r_b0);
                mul_b = MB'(r_x0);
            end
            OP_B1: begin
                mul_a = MA'(r_b1);
                mul_b = MB'(r_x1);
            end
            OP_B2: begin
                mul_a = MA'(r_b2);
                mul_b = MB'(r_x2);
            end
            OP_A1: begin
                mul_a = MA'(r_a1);
                mul_b = MB'(r_y1);
            end
            OP_A2: begin
                mul_a = MA'(r_a2);
                mul_b = MB'(r_y2);
            end
            OP_RAMP: begin
                mul_a = MA'(gain_diff);
                mul_b = MB'($signed({1'b0, pos_j}));
            end
            OP_SCALE: begin
                mul_a = MA'(r_gain);
                mul_b = MB'(r_y0);
            end
            default: begin
                mul_a = MA'(r_b0);
            end
        endcase
    end

    bqgr_mul #(
        .A_BITS (MA),
        .B_BITS (MB)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (ctrl.mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // filter value: round half up at q.14, then clamp to sample range
    assign acc_rnd = f_sat_acc(r_acc, ROUND_Y, 1'b0);
    assign y_sh    = acc_rnd >>> COEF_FRAC;
    always_comb begin
        if ((&y_sh[ACC_BITS-1:SAMPLE_BITS-1]) || !(|y_sh[ACC_BITS-1:SAMPLE_BITS-1])) begin
            y_sat = y_sh[SAMPLE_BITS-1:0];
        end else if (y_sh[ACC_BITS-1]) begin
            y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // ramp gain: previous gain plus floor of delta * j / 2^k
    assign ramp_sh = prod >>> k;
    assign n_gain  = $signed({1'b0, r_prev_gain}) + (GAIN_BITS + 1)'(ramp_sh);

    // scaled output: round half up at q1.16, then clamp
    assign scl_rnd = prod + ROUND_G;
    assign scl_sh  = SW'(scl_rnd >>> GAIN_FRAC);
    always_comb begin
        if ((&scl_sh[SW-1:SAMPLE_BITS-1]) || !(|scl_sh[SW-1:SAMPLE_BITS-1])) begin
            scl_sat = scl_sh[SAMPLE_BITS-1:0];
        end else if (scl_sh[SW-1]) begin
            scl_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            scl_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0     <= COEF_BITS'(B0_RESET);
            r_b1     <= '0;
            r_b2     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
            r_target <= GAIN_BITS'(GAIN_RESET);
            r_log2   <= LOG2_BITS'(BLOCK_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_B0:    r_b0     <= i_cfg_data[COEF_BITS-1:0];
                CFG_B1:    r_b1     <= i_cfg_data[COEF_BITS-1:0];
                CFG_B2:    r_b2     <= i_cfg_data[COEF_BITS-1:0];
                CFG_A1:    r_a1     <= i_cfg_data[COEF_BITS-1:0];
                CFG_A2:    r_a2     <= i_cfg_data[COEF_BITS-1:0];
                CFG_GAIN:  r_target <= i_cfg_data[GAIN_BITS-1:0];
                CFG_BLOCK: r_log2   <= i_cfg_data[LOG2_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // filter and ramp state, committed when the result is handed out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
            r_pos       <= '0;
            r_prev_gain <= '0;
        end else if (ctrl.out_load) begin
            r_x2 <= r_x1;
            r_x1 <= r_x0;
            r_y2 <= r_y1;
            r_y1 <= r_y0;
            if (pos_j == last) begin
                r_pos       <= '0;
                r_prev_gain <= r_target;
            end else begin
                r_pos <= pos_j + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_x0 <= i_in.sample_in;
        end
        if (in_beat) begin
            r_acc <= '0;
        end else if (ctrl.acc_op == ACC_ADD) begin
            r_acc <= f_sat_acc(r_acc, ACC_BITS'(prod), 1'b0);
        end else if (ctrl.acc_op == ACC_SUB) begin
            r_acc <= f_sat_acc(r_acc, ACC_BITS'(prod), 1'b1);
        end
        if (ctrl.fin_load) begin
            r_y0   <= y_sat;
            r_gain <= n_gain;
        end
        if (ctrl.out_load) begin
            r_out <= scl_sat;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end
endmodule

`default_nettype wire

// ===== rtl/bqgr_mul.sv =====
// ----------------------------------------------------------------------------
// bqgr_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module bqgr_mul #(
    parameter int A_BITS = 18,
    parameter int B_BITS = 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic signed [A_BITS-1:0]        i_a,
    input  wire logic signed [B_BITS-1:0]        i_b,
    output logic signed [A_BITS+B_BITS-1:0]      o_prod
);
    logic signed [A_BITS+B_BITS-1:0] r_prod;
    logic signed [A_BITS+B_BITS-1:0] n_prod;

    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;
endmodule

`default_nettype wire

// ===== rtl/bqgr_seq.sv =====
// ----------------------------------------------------------------------------
// bqgr_seq
// sequencer stepping the shared multiplier through one sample
// ----------------------------------------------------------------------------
`default_nettype none

module bqgr_seq (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_busy,
    output logic         o_in_ready,
    output bqgr_pkg::t_ctrl o_ctrl
);
    import bqgr_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_SCALE) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_ctrl.op       = OP_B0;
        o_ctrl.mul_en   = 1'b0;
        o_ctrl.acc_op   = ACC_HOLD;
        o_ctrl.fin_load = 1'b0;
        o_ctrl.out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_RUN: begin
                // issue product of this step, accumulate the one before
                case (r_cnt)
                    3'd0: begin
                        o_ctrl.op     = OP_B0;
                        o_ctrl.mul_en = 1'b1;
                    end
                    3'd1: begin
                        o_ctrl.op     = OP_B1;
                        o_ctrl.mul_en = 1'b1;
                        o_ctrl.acc_op = ACC_ADD;
                    end
                    3'd2: begin
                        o_ctrl.op     = OP_B2;
                        o_ctrl.mul_en = 1'b1;
                        o_ctrl.acc_op = ACC_ADD;
                    end
                    3'd3: begin
                        o_ctrl.op     = OP_A1;
                        o_ctrl.mul_en = 1'b1;
                        o_ctrl.acc_op = ACC_ADD;
                    end
                    3'd4: begin
                        o_ctrl.op     = OP_A2;
                        o_ctrl.mul_en = 1'b1;
                        o_ctrl.acc_op = ACC_SUB;
                    end
                    3'd5: begin
                        o_ctrl.op     = OP_RAMP;
                        o_ctrl.mul_en = 1'b1;
                        o_ctrl.acc_op = ACC_SUB;
                    end
                    CNT_FIN: begin
                        o_ctrl.fin_load = 1'b1;
                    end
                    CNT_SCALE: begin
                        o_ctrl.op     = OP_SCALE;
                        o_ctrl.mul_en = 1'b1;
                    end
                    default: begin
                        o_ctrl.mul_en = 1'b0;
                    end
                endcase
            end
            ST_DONE: begin
                o_ctrl.out_load = !i_out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end
endmodule

`default_nettype wire
